/* rtl/iap_pkg.sv */
// Shared types, constants and the angle scaling function for the attitude packet parser.
`timescale 1ns / 1ps

package iap_pkg;

  localparam int BYTE_W  = 8;
  localparam int ANGLE_W = 18;
  localparam int WORD_W  = 16;
  localparam int PROD_W  = 22;
  localparam int NUM_DATA = 6;
  localparam int MASK_W  = 3;

  localparam logic [BYTE_W-1:0] HDR_S = 8'h73;
  localparam logic [BYTE_W-1:0] HDR_N = 8'h6E;
  localparam logic [BYTE_W-1:0] HDR_P = 8'h70;

  localparam int FLAG_YAW   = 2;
  localparam int FLAG_PITCH = 1;
  localparam int FLAG_ROLL  = 0;

  localparam logic signed [PROD_W-1:0] SCALE_MUL = 22'sd45;
  localparam int SCALE_SHIFT = 4;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    logic                               done;
    logic [MASK_W-1:0]                  flags;
    logic [NUM_DATA-1:0][BYTE_W-1:0]    data;
  } pkt_t;

  // floor(raw * 45 / 16) on a big-endian signed 16-bit word
  function automatic angle_t scale_word(input logic [WORD_W-1:0] word);
    logic signed [PROD_W-1:0] raw;
    logic signed [PROD_W-1:0] prod;
    raw  = PROD_W'($signed(word));
    prod = raw * SCALE_MUL;
    return angle_t'(prod[PROD_W-1:SCALE_SHIFT]);
  endfunction

endpackage

/* rtl/iap_parse.sv */
// Input register, header and type check sequencer, and payload byte capture.
`timescale 1ns / 1ps

module iap_parse (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [iap_pkg::BYTE_W-1:0] s_axis_tdata,
  input  logic [iap_pkg::BYTE_W-1:0] sensor_packet_code,
  input  logic                       out_free,
  output iap_pkg::pkt_t              pkt
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_N, PH_P, PH_TYPE, PH_LEN, PH_FLAG1, PH_FLAG2,
    PH_D0, PH_D1, PH_D2, PH_D3, PH_D4, PH_D5
  } phase_t;

  phase_t                      phase;
  phase_t                      phase_next;
  phase_t                      resync;
  logic                        in_valid;
  logic [iap_pkg::BYTE_W-1:0]  in_byte;
  logic [iap_pkg::MASK_W-1:0]  flags;
  logic [4:0][iap_pkg::BYTE_W-1:0] payload;
  logic                        advance;

  assign advance       = in_valid && ((phase != PH_D5) || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign resync        = (in_byte == iap_pkg::HDR_S) ? PH_N : PH_HUNT;

  always_comb begin
    case (phase)
      PH_HUNT:  phase_next = resync;
      PH_N:     phase_next = (in_byte == iap_pkg::HDR_N) ? PH_P : resync;
      PH_P:     phase_next = (in_byte == iap_pkg::HDR_P) ? PH_TYPE : resync;
      PH_TYPE:  phase_next = (in_byte == sensor_packet_code) ? PH_LEN : resync;
      PH_LEN:   phase_next = PH_FLAG1;
      PH_FLAG1: phase_next = PH_FLAG2;
      PH_FLAG2: phase_next = PH_D0;
      PH_D0:    phase_next = PH_D1;
      PH_D1:    phase_next = PH_D2;
      PH_D2:    phase_next = PH_D3;
      PH_D3:    phase_next = PH_D4;
      PH_D4:    phase_next = PH_D5;
      PH_D5:    phase_next = PH_HUNT;
      default:  phase_next = resync;
    endcase
  end

  always_comb begin
    pkt.done  = in_valid && (phase == PH_D5);
    pkt.flags = flags;
    pkt.data  = {in_byte, payload[4], payload[3], payload[2], payload[1], payload[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      phase    <= PH_HUNT;
      flags    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_byte  <= s_axis_tdata;
      end
      if (advance) begin
        phase <= phase_next;
        case (phase)
          PH_FLAG1: flags      <= in_byte[7:5];
          PH_D0:    payload[0] <= in_byte;
          PH_D1:    payload[1] <= in_byte;
          PH_D2:    payload[2] <= in_byte;
          PH_D3:    payload[3] <= in_byte;
          PH_D4:    payload[4] <= in_byte;
          default:  ;
        endcase
      end
    end
  end

endmodule

/* rtl/iap_scale.sv */
// Word selection, angle scaling and the held-angle result register.
`timescale 1ns / 1ps

module iap_scale (
  input  logic                       clk,
  input  logic                       rst,
  input  iap_pkg::pkt_t              pkt,
  output logic                       out_free,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output iap_pkg::angle_t            yaw_angle,
  output iap_pkg::angle_t            pitch_angle,
  output iap_pkg::angle_t            roll_angle,
  output logic [iap_pkg::MASK_W-1:0] updated_mask
);

  logic [iap_pkg::WORD_W-1:0] word0;
  logic [iap_pkg::WORD_W-1:0] word1;
  logic [iap_pkg::WORD_W-1:0] word2;
  logic [iap_pkg::WORD_W-1:0] pitch_word;
  logic [iap_pkg::WORD_W-1:0] roll_word;
  iap_pkg::angle_t            yaw_next;
  iap_pkg::angle_t            pitch_next;
  iap_pkg::angle_t            roll_next;
  logic                       load;

  assign word0 = {pkt.data[0], pkt.data[1]};
  assign word1 = {pkt.data[2], pkt.data[3]};
  assign word2 = {pkt.data[4], pkt.data[5]};

  always_comb begin
    pitch_word = pkt.flags[iap_pkg::FLAG_YAW] ? word1 : word0;
    case ({pkt.flags[iap_pkg::FLAG_YAW], pkt.flags[iap_pkg::FLAG_PITCH]})
      2'b00:   roll_word = word0;
      2'b11:   roll_word = word2;
      default: roll_word = word1;
    endcase
    yaw_next   = pkt.flags[iap_pkg::FLAG_YAW]   ? iap_pkg::scale_word(word0)      : yaw_angle;
    pitch_next = pkt.flags[iap_pkg::FLAG_PITCH] ? iap_pkg::scale_word(pitch_word) : pitch_angle;
    roll_next  = pkt.flags[iap_pkg::FLAG_ROLL]  ? iap_pkg::scale_word(roll_word)  : roll_angle;
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign load     = pkt.done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      yaw_angle     <= '0;
      pitch_angle   <= '0;
      roll_angle    <= '0;
      updated_mask  <= '0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
      yaw_angle     <= yaw_next;
      pitch_angle   <= pitch_next;
      roll_angle    <= roll_next;
      updated_mask  <= pkt.flags;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

/* rtl/imu_attitude_packet_parser_top.sv */
// Top level of the attitude packet parser: config register, parser and result stage.
`timescale 1ns / 1ps

// Takes one received byte per cycle and returns one result per complete packet of
// the configured type ('s' 'n' 'p', type, length, two flag bytes, six data bytes).
// The parser accepts a byte every cycle while the result register is free or being
// drained; the result register loads from the input register. Yaw, pitch and roll
// are in 1/256 degree, and an angle not selected by the flags repeats its previous
// value. sensor_packet_code resets to 0 and is written with cfg_wr_en.
module imu_attitude_packet_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // sensor_packet_code
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // [17:0] yaw_angle, [35:18] pitch_angle,
                                     // [53:36] roll_angle, [56:54] updated_mask
);

  logic [iap_pkg::BYTE_W-1:0] sensor_packet_code;
  iap_pkg::pkt_t              pkt;
  logic                       out_free;
  iap_pkg::angle_t            yaw_angle;
  iap_pkg::angle_t            pitch_angle;
  iap_pkg::angle_t            roll_angle;
  logic [iap_pkg::MASK_W-1:0] updated_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_packet_code <= '0;
    end else if (cfg_wr_en) begin
      sensor_packet_code <= cfg_wr_data;
    end
  end

  iap_parse u_parse (
    .clk                (clk),
    .rst                (rst),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .sensor_packet_code (sensor_packet_code),
    .out_free           (out_free),
    .pkt                (pkt)
  );

  iap_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .pkt           (pkt),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .yaw_angle     (yaw_angle),
    .pitch_angle   (pitch_angle),
    .roll_angle    (roll_angle),
    .updated_mask  (updated_mask)
  );

  assign m_axis_tdata = {7'b0, updated_mask, roll_angle, pitch_angle, yaw_angle};

endmodule

/* rtl/iap_checker.sv */
// Port-level checks for the attitude packet parser and their bind to the top level.
`timescale 1ns / 1ps

module iap_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (m_axis_tdata[17:0] != $past(m_axis_tdata[17:0]))
      |-> m_axis_tvalid && m_axis_tdata[56])
    else $error("yaw changed without a yaw update");

  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (m_axis_tdata[35:18] != $past(m_axis_tdata[35:18]))
      |-> m_axis_tvalid && m_axis_tdata[55])
    else $error("pitch changed without a pitch update");

  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (m_axis_tdata[53:36] != $past(m_axis_tdata[53:36]))
      |-> m_axis_tvalid && m_axis_tdata[54])
    else $error("roll changed without a roll update");

endmodule

bind imu_attitude_packet_parser_top iap_checker u_iap_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/attitude_checker.sv */
// Checker for the attitude packet parser: tracks packets and compares each result.
`timescale 1ns / 1ps

module attitude_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [3:0] {
    SEEK_S, SEEK_N, SEEK_P, TYPE_CHK, LEN_SKIP, FLAG_HI, FLAG_LO, DATA
  } parse_phase_t;

  typedef struct packed {
    iap_pkg::angle_t            yaw;
    iap_pkg::angle_t            pitch;
    iap_pkg::angle_t            roll;
    logic [iap_pkg::MASK_W-1:0] mask;
  } attitude_t;

  attitude_t                  expected_attitudes[$];
  parse_phase_t               phase;
  parse_phase_t               resync;
  logic [iap_pkg::BYTE_W-1:0] packet_code;
  logic [iap_pkg::MASK_W-1:0] selected;
  logic [iap_pkg::BYTE_W-1:0] payload[iap_pkg::NUM_DATA];
  iap_pkg::angle_t            held[iap_pkg::MASK_W];
  int                         data_idx;
  int                         mismatches;

  // floor(raw * 45 / 16) in 1/256 degree
  function automatic iap_pkg::angle_t deg256_of(input logic [15:0] word);
    int product;
    product = int'($signed(word)) * 45;
    return iap_pkg::angle_t'(product >>> 4);
  endfunction

  always @(posedge clk) begin
    attitude_t    want;
    attitude_t    got;
    logic [7:0]   b;
    int           pos;
    if (rst) begin
      expected_attitudes.delete();
      phase       = SEEK_S;
      packet_code = '0;
      selected    = '0;
      data_idx    = 0;
      mismatches  = 0;
      for (int i = 0; i < iap_pkg::MASK_W; i++) held[i] = '0;
    end else begin
      if (cfg_wr_en) packet_code = cfg_wr_data;

      if (m_axis_tvalid && m_axis_tready) begin
        got.yaw   = iap_pkg::angle_t'(m_axis_tdata[17:0]);
        got.pitch = iap_pkg::angle_t'(m_axis_tdata[35:18]);
        got.roll  = iap_pkg::angle_t'(m_axis_tdata[53:36]);
        got.mask  = m_axis_tdata[56:54];
        if (expected_attitudes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: yaw %0d pitch %0d roll %0d mask %b",
                     got.yaw, got.pitch, got.roll, got.mask);
        end else begin
          want = expected_attitudes.pop_front();
          if (got.yaw !== want.yaw || got.pitch !== want.pitch ||
              got.roll !== want.roll || got.mask !== want.mask) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected yaw %0d pitch %0d roll %0d mask %b,",
                        " got yaw %0d pitch %0d roll %0d mask %b"},
                       want.yaw, want.pitch, want.roll, want.mask,
                       got.yaw, got.pitch, got.roll, got.mask);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        b      = s_axis_tdata;
        resync = (b == iap_pkg::HDR_S) ? SEEK_N : SEEK_S;
        case (phase)
          SEEK_S:   phase = resync;
          SEEK_N:   phase = (b == iap_pkg::HDR_N) ? SEEK_P : resync;
          SEEK_P:   phase = (b == iap_pkg::HDR_P) ? TYPE_CHK : resync;
          TYPE_CHK: phase = (b == packet_code) ? LEN_SKIP : resync;
          LEN_SKIP: phase = FLAG_HI;
          FLAG_HI: begin
            selected = b[7:5];
            phase    = FLAG_LO;
          end
          FLAG_LO: begin
            data_idx = 0;
            phase    = DATA;
          end
          DATA: begin
            payload[data_idx] = b;
            if (data_idx == iap_pkg::NUM_DATA - 1) begin
              pos = 0;
              for (int ch = iap_pkg::MASK_W - 1; ch >= 0; ch--) begin
                if (selected[ch]) begin
                  held[ch] = deg256_of({payload[pos], payload[pos + 1]});
                  pos += 2;
                end
              end
              want.yaw   = held[iap_pkg::FLAG_YAW];
              want.pitch = held[iap_pkg::FLAG_PITCH];
              want.roll  = held[iap_pkg::FLAG_ROLL];
              want.mask  = selected;
              expected_attitudes.push_back(want);
              phase = SEEK_S;
            end else begin
              data_idx++;
            end
          end
          default: phase = resync;
        endcase
      end
    end
    pending    <= expected_attitudes.size();
    fail_count <= mismatches;
  end

endmodule

/* sim/tb.sv */
// Testbench top for the attitude packet parser: stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int PKT_LEN = 7 + iap_pkg::NUM_DATA;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          pushed_count;
  int          tx_calm;
  int          rx_calm;

  always #10 clk = ~clk;

  imu_attitude_packet_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  attitude_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(5, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0: return iap_pkg::HDR_S;
      1: return iap_pkg::HDR_N;
      2: return iap_pkg::HDR_P;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    pushed_count++;
  endtask

  task automatic send_packet(input logic [7:0] code, input int keep);
    logic [7:0] pkt[PKT_LEN];
    pkt[0] = iap_pkg::HDR_S;
    pkt[1] = iap_pkg::HDR_N;
    pkt[2] = iap_pkg::HDR_P;
    pkt[3] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : code;
    pkt[4] = 8'($urandom);
    pkt[5] = 8'($urandom);
    pkt[6] = 8'($urandom);
    for (int i = 7; i < PKT_LEN; i++) pkt[i] = data_byte();
    for (int i = 0; i < keep; i++) push_byte(pkt[i]);
  endtask

  task automatic load_packet_code(input logic [7:0] code);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver: random stalls, two long hold-offs to back up the parser
  initial begin
    int stall;
    int taken;
    taken         = 0;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 15 || taken == 45) stall = 400;
      else stall = draw_wait(rx_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin
    logic [7:0] directed[$];
    logic [7:0] codes[5];
    int         goal;
    int         pick;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    pushed_count  = 0;
    tx_calm       = 0;
    rx_calm       = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // resync on a repeated 's', all three angles selected: yaw and pitch at the word extremes, roll at -1
    directed = '{iap_pkg::HDR_S, iap_pkg::HDR_S, iap_pkg::HDR_N, iap_pkg::HDR_P,
                 8'h00, 8'hFF, 8'hE0, 8'h00,
                 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
    // type byte 's' restarts the header; no angle selected
                 iap_pkg::HDR_S, iap_pkg::HDR_N, iap_pkg::HDR_P,
                 iap_pkg::HDR_S, iap_pkg::HDR_N, iap_pkg::HDR_P, 8'h00, 8'h00,
                 8'h1F, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};
    foreach (directed[i]) push_byte(directed[i]);

    codes = '{8'hFF, iap_pkg::HDR_S, 8'($urandom), 8'h00, 8'($urandom)};
    foreach (codes[c]) begin
      load_packet_code(codes[c]);
      goal = pushed_count + 165;
      while (pushed_count < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) send_packet(codes[c], PKT_LEN);
        else if (pick < 17) send_packet(codes[c], $urandom_range(1, PKT_LEN - 1));
        else repeat ($urandom_range(1, 6)) push_byte(noise_byte());
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS imu_attitude_packet_parser_top");
    end else begin
      $display("FAIL imu_attitude_packet_parser_top");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL imu_attitude_packet_parser_top");
    $finish;
  end

endmodule
